@@ rtl/texture_sampler_nearest_bilinear_macros.svh @@
// Assertion macros for the texture sampler.
`ifndef TEXTURE_SAMPLER_NEAREST_BILINEAR_MACROS_SVH
`define TEXTURE_SAMPLER_NEAREST_BILINEAR_MACROS_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle (consequent may be a sequence)
`define TSNB_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("texture sampler check failed");
// antecedent implies consequent in the next cycle
`define TSNB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("texture sampler check failed");
`else
`define TSNB_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TSNB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/tsnb_pkg.sv @@
// Shared constants for the texture sampler.
package tsnb_pkg;
   localparam int MAX_DIM_DEF   = 64;
   localparam int FRAC_BITS_DEF = 8;

   localparam int COORD_W    = 20;
   localparam int COORD_FRAC = 16;
   localparam int CHAN_W     = 8;
   localparam int COLOR_W    = 32;
   localparam int NUM_CHAN   = COLOR_W / CHAN_W;
   localparam int TEXEL_XY_W = 6;
   localparam int CFG_DIM_W  = 7;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // request kinds
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   // filter modes
   localparam logic FILTER_NEAREST  = 1'b0;
   localparam logic FILTER_BILINEAR = 1'b1;

   // register indexes
   typedef logic [1:0] reg_idx_type;
   localparam reg_idx_type REG_FILTER_MODE = 2'd0;
   localparam reg_idx_type REG_TEX_WIDTH   = 2'd1;
   localparam reg_idx_type REG_TEX_HEIGHT  = 2'd2;
endpackage

@@ rtl/texture_sampler_nearest_bilinear.sv @@
// Top level of the texture sampler: register port, pipeline and texel store.
//
// Requests enter on start with the req_ ports; busy is always low, so one
// request is taken every clock. A write request (req_type 0) stores one texel
// at (req_texel_x, req_texel_y) and gives no result; writes outside the store
// are dropped. A sample request (req_type 1) gives one color on
// rsp_sample_color, marked by rsp_strobe for exactly one cycle. Sustained rate is
// one request per clock.
// Pipeline: coordinate multiply, index split, texel store read (four copies of
// the store, one per neighbor, so all four texels are read at once),
// horizontal blend, vertical blend. Nearest mode runs the same path with zero
// weights. Texel writes land at the store-read stage, so every sample sees
// exactly the writes requested before it.
// Results cannot be held off; there is no stall anywhere in the pipeline.
// Reset clears the pipeline valid bits and sets nearest mode and a 64 by 64
// size; texel contents are undefined until written. The user must write registers
// over the APB port only while no request is in flight; the block does not enforce it.
`include "texture_sampler_nearest_bilinear_macros.svh"
module texture_sampler_nearest_bilinear import tsnb_pkg::*; #(
   parameter int MAX_DIM   = MAX_DIM_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_type,
   input  logic [TEXEL_XY_W-1:0]      req_texel_x,
   input  logic [TEXEL_XY_W-1:0]      req_texel_y,
   input  logic [COLOR_W-1:0]         req_texel_color,
   input  logic signed [COORD_W-1:0]  req_coord_u,
   input  logic signed [COORD_W-1:0]  req_coord_v,
   output logic                       rsp_strobe,
   output logic [COLOR_W-1:0]         rsp_sample_color,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [CSR_ADDR_W-1:0]      paddr,
   input  logic [CSR_DATA_W-1:0]      pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);
   localparam int DW    = $clog2(MAX_DIM + 1);
   localparam int IW    = $clog2(MAX_DIM);
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);

   // configuration registers
   logic                 filter_mode_ff, filter_mode_in;
   logic [CFG_DIM_W-1:0] tex_width_ff, tex_width_in;
   logic [CFG_DIM_W-1:0] tex_height_ff, tex_height_in;
   logic                 csr_write;
   reg_idx_type          csr_idx;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_idx   = paddr[3:2];

   always_comb begin
      filter_mode_in = filter_mode_ff;
      tex_width_in   = tex_width_ff;
      tex_height_in  = tex_height_ff;
      if (csr_write) begin
         unique case (csr_idx)
            REG_FILTER_MODE: filter_mode_in = pwdata[0];
            REG_TEX_WIDTH:   tex_width_in   = pwdata[CFG_DIM_W-1:0];
            REG_TEX_HEIGHT:  tex_height_in  = pwdata[CFG_DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff <= FILTER_NEAREST;
         tex_width_ff   <= CFG_DIM_W'(64);
         tex_height_ff  <= CFG_DIM_W'(64);
      end else begin
         filter_mode_ff <= filter_mode_in;
         tex_width_ff   <= tex_width_in;
         tex_height_ff  <= tex_height_in;
      end
   end

   // register readback
   always_comb begin
      unique case (csr_idx)
         REG_FILTER_MODE: prdata = CSR_DATA_W'(filter_mode_ff);
         REG_TEX_WIDTH:   prdata = CSR_DATA_W'(tex_width_ff);
         REG_TEX_HEIGHT:  prdata = CSR_DATA_W'(tex_height_ff);
         default:         prdata = '0;
      endcase
   end

   // effective size: zero acts as one, larger than the store acts as full size
   function automatic logic [DW-1:0] eff_dim(input logic [CFG_DIM_W-1:0] d);
      if (d == '0) begin
         return DW'(1);
      end else if (d > MAX_DIM) begin
         return DW'(MAX_DIM);
      end
      return DW'(d);
   endfunction

   logic [DW-1:0] dim_w, dim_h;
   assign dim_w = eff_dim(tex_width_ff);
   assign dim_h = eff_dim(tex_height_ff);

   // request acceptance
   logic accept, acc_sample, acc_write;
   assign busy       = 1'b0;
   assign accept     = start && !busy;
   assign acc_sample = accept && (req_type == REQ_SAMPLE);
   assign acc_write  = accept && (req_type == REQ_WRITE) &&
                       (req_texel_x < MAX_DIM) && (req_texel_y < MAX_DIM);

   // axis units: stage A and stage B
   logic [IW-1:0]        x0, x1, y0, y1;
   logic [FRAC_BITS-1:0] tx, ty;

   tsnb_axis #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_axis_u (
      .clock (clock),
      .coord (req_coord_u),
      .dim   (dim_w),
      .mode  (filter_mode_ff),
      .idx0  (x0),
      .idx1  (x1),
      .frac  (tx)
   );

   tsnb_axis #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_axis_v (
      .clock (clock),
      .coord (req_coord_v),
      .dim   (dim_h),
      .mode  (filter_mode_ff),
      .idx0  (y0),
      .idx1  (y1),
      .frac  (ty)
   );

   // write requests travel alongside so they reach the store in order
   logic               s_a_sample_ff, s_b_sample_ff, s_r_sample_ff;
   logic               s_a_write_ff, s_b_write_ff;
   logic [AW-1:0]      s_a_waddr_ff, s_b_waddr_ff, waddr_in;
   logic [COLOR_W-1:0] s_a_wdata_ff, s_b_wdata_ff;
   logic [FRAC_BITS-1:0] tx_r_ff, ty_r_ff;

   assign waddr_in = AW'(req_texel_y) * AW'(MAX_DIM) + AW'(req_texel_x);

   always_ff @(posedge clock) begin
      if (reset) begin
         s_a_sample_ff <= 1'b0;
         s_b_sample_ff <= 1'b0;
         s_r_sample_ff <= 1'b0;
         s_a_write_ff  <= 1'b0;
         s_b_write_ff  <= 1'b0;
      end else begin
         s_a_sample_ff <= acc_sample;
         s_b_sample_ff <= s_a_sample_ff;
         s_r_sample_ff <= s_b_sample_ff;
         s_a_write_ff  <= acc_write;
         s_b_write_ff  <= s_a_write_ff;
      end
   end

   always_ff @(posedge clock) begin
      s_a_waddr_ff <= waddr_in;
      s_a_wdata_ff <= req_texel_color;
      s_b_waddr_ff <= s_a_waddr_ff;
      s_b_wdata_ff <= s_a_wdata_ff;
      tx_r_ff      <= tx;
      ty_r_ff      <= ty;
   end

   // texel store: one copy per neighbor, all written together
   logic [AW-1:0]      rd_addr [4];
   logic [COLOR_W-1:0] rd_data [4];

   assign rd_addr[0] = AW'(y0) * AW'(MAX_DIM) + AW'(x0);
   assign rd_addr[1] = AW'(y0) * AW'(MAX_DIM) + AW'(x1);
   assign rd_addr[2] = AW'(y1) * AW'(MAX_DIM) + AW'(x0);
   assign rd_addr[3] = AW'(y1) * AW'(MAX_DIM) + AW'(x1);

   for (genvar g = 0; g < 4; g++) begin : g_store
      tsnb_ram #(.WIDTH(COLOR_W), .DEPTH(DEPTH)) u_ram (
         .clock (clock),
         .we    (s_b_write_ff),
         .waddr (s_b_waddr_ff),
         .wdata (s_b_wdata_ff),
         .raddr (rd_addr[g]),
         .rdata (rd_data[g])
      );
   end

   // blend stages
   tsnb_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (s_r_sample_ff),
      .tx        (tx_r_ff),
      .ty        (ty_r_ff),
      .c00       (rd_data[0]),
      .c10       (rd_data[1]),
      .c01       (rd_data[2]),
      .c11       (rd_data[3]),
      .valid_out (rsp_strobe),
      .color     (rsp_sample_color)
   );

   // every sample request gives its result
   `TSNB_ASSERT_IMPLIES(a_sample_result, clock, reset, acc_sample, ##5 rsp_strobe)
   // no result without an earlier sample request
   `TSNB_ASSERT_IMPLIES(a_no_spurious, clock, reset, rsp_strobe, $past(acc_sample, 5))
   // a write request never yields a result
   `TSNB_ASSERT_NEXT(a_write_silent, clock, reset, accept && (req_type == REQ_WRITE),
                     ##4 !rsp_strobe)
endmodule

@@ rtl/tsnb_ram.sv @@
// Generic single write, single read RAM with registered read data.
module tsnb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/tsnb_axis.sv @@
// One coordinate axis: scale by the texture size, then split into indices and weight.
module tsnb_axis import tsnb_pkg::*; #(
   parameter int MAX_DIM   = MAX_DIM_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic signed [COORD_W-1:0]         coord,
   input  logic [$clog2(MAX_DIM+1)-1:0]      dim,
   input  logic                              mode,
   output logic [$clog2(MAX_DIM)-1:0]        idx0,
   output logic [$clog2(MAX_DIM)-1:0]        idx1,
   output logic [FRAC_BITS-1:0]              frac
);
   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int IW = $clog2(MAX_DIM);
   localparam int PW = COORD_W + DW + 1;
   localparam int FW = PW + 1;
   localparam int BW = FW - COORD_FRAC;
   localparam logic [COORD_FRAC-1:0] COORD_MAX = '1;

   // stage A: clamp for nearest, multiply by size
   logic signed [COORD_W-1:0] cin;
   logic signed [PW-1:0]      cin_ext, dim_ext, prod_in, prod_ff;
   logic                      mode_ff;
   logic [DW-1:0]             dim_ff;

   always_comb begin
      cin = coord;
      if (mode == FILTER_NEAREST) begin
         if (coord < 0) begin
            cin = '0;
         end else if (coord[COORD_W-1:COORD_FRAC] != '0) begin
            cin = COORD_W'($signed({1'b0, COORD_MAX}));
         end
      end
      cin_ext = PW'(cin);
      dim_ext = PW'($signed({1'b0, dim}));
      prod_in = cin_ext * dim_ext;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      mode_ff <= mode;
      dim_ff  <= dim;
   end

   // stage B: half-texel offset (bilinear only), floor, clamp both neighbors
   logic signed [FW-1:0] f_val;
   logic signed [BW-1:0] base, base1, hi;
   logic [IW-1:0]        idx0_in, idx1_in, idx0_ff, idx1_ff;
   logic [FRAC_BITS-1:0] frac_in, frac_ff;

   always_comb begin
      f_val = FW'(prod_ff);
      if (mode_ff == FILTER_BILINEAR) begin
         f_val = FW'(prod_ff) - FW'($signed({1'b0, 1'b1, {(COORD_FRAC-1){1'b0}}}));
      end
      base  = BW'(f_val >>> COORD_FRAC);
      base1 = base + BW'(1);
      hi    = BW'($signed({1'b0, dim_ff})) - BW'(1);
      frac_in = (mode_ff == FILTER_BILINEAR) ?
                f_val[COORD_FRAC-1 -: FRAC_BITS] : '0;
      if (base < 0) begin
         idx0_in = '0;
      end else if (base > hi) begin
         idx0_in = IW'(hi);
      end else begin
         idx0_in = IW'(base);
      end
      if (base1 < 0) begin
         idx1_in = '0;
      end else if (base1 > hi) begin
         idx1_in = IW'(hi);
      end else begin
         idx1_in = IW'(base1);
      end
   end

   always_ff @(posedge clock) begin
      idx0_ff <= idx0_in;
      idx1_ff <= idx1_in;
      frac_ff <= frac_in;
   end

   assign idx0 = idx0_ff;
   assign idx1 = idx1_ff;
   assign frac = frac_ff;
endmodule

@@ rtl/tsnb_blend.sv @@
// Two-stage per-channel blend: horizontal lerp, then vertical lerp.
module tsnb_blend import tsnb_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_in,
   input  logic [FRAC_BITS-1:0] tx,
   input  logic [FRAC_BITS-1:0] ty,
   input  logic [COLOR_W-1:0]   c00,
   input  logic [COLOR_W-1:0]   c10,
   input  logic [COLOR_W-1:0]   c01,
   input  logic [COLOR_W-1:0]   c11,
   output logic                 valid_out,
   output logic [COLOR_W-1:0]   color
);
   localparam int PRW = CHAN_W + FRAC_BITS + 2;

   // a + floor((b - a) * t / 2^FRAC_BITS); result always lies in [a, b]
   function automatic logic [CHAN_W-1:0] lerp_chan(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b,
                                                   input logic [FRAC_BITS-1:0] t);
      logic signed [CHAN_W:0]  diff;
      logic signed [PRW-1:0]   prod;
      logic signed [PRW-1:0]   step;
      diff = $signed({1'b0, b}) - $signed({1'b0, a});
      prod = PRW'(diff) * PRW'($signed({1'b0, t}));
      step = prod >>> FRAC_BITS;
      return a + step[CHAN_W-1:0];
   endfunction

   logic [COLOR_W-1:0]   top_in, bot_in, top_ff, bot_ff, color_in, color_ff;
   logic [FRAC_BITS-1:0] ty_ff;
   logic                 valid_h_ff, valid_v_ff;

   // horizontal blend of both rows
   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         top_in[ch*CHAN_W +: CHAN_W] = lerp_chan(c00[ch*CHAN_W +: CHAN_W],
                                                 c10[ch*CHAN_W +: CHAN_W], tx);
         bot_in[ch*CHAN_W +: CHAN_W] = lerp_chan(c01[ch*CHAN_W +: CHAN_W],
                                                 c11[ch*CHAN_W +: CHAN_W], tx);
      end
   end

   // vertical blend
   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         color_in[ch*CHAN_W +: CHAN_W] = lerp_chan(top_ff[ch*CHAN_W +: CHAN_W],
                                                   bot_ff[ch*CHAN_W +: CHAN_W], ty_ff);
      end
   end

   always_ff @(posedge clock) begin
      top_ff   <= top_in;
      bot_ff   <= bot_in;
      ty_ff    <= ty;
      color_ff <= color_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_h_ff <= 1'b0;
         valid_v_ff <= 1'b0;
      end else begin
         valid_h_ff <= valid_in;
         valid_v_ff <= valid_h_ff;
      end
   end

   assign valid_out = valid_v_ff;
   assign color     = color_ff;
endmodule

@@ test/tsnb_checker.sv @@
// Checker for the texture sampler: tracks texels and registers, predicts colors, compares.
module tsnb_checker import tsnb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic                      req_type,
   input  logic [TEXEL_XY_W-1:0]     req_texel_x,
   input  logic [TEXEL_XY_W-1:0]     req_texel_y,
   input  logic [COLOR_W-1:0]        req_texel_color,
   input  logic signed [COORD_W-1:0] req_coord_u,
   input  logic signed [COORD_W-1:0] req_coord_v,
   input  logic                      rsp_strobe,
   input  logic [COLOR_W-1:0]        rsp_sample_color,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   input  logic                      pready,
   output int                        fail_count,
   output int                        pending,
   output int                        colors_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIM = MAX_DIM_DEF;
   localparam int WFRAC = FRAC_BITS_DEF;

   logic [COLOR_W-1:0]   texel_mem [DIM*DIM];
   logic                 cfg_mode;
   logic [CFG_DIM_W-1:0] cfg_w;
   logic [CFG_DIM_W-1:0] cfg_h;
   logic [COLOR_W-1:0]   color_fifo [$];

   // size register as the sampler uses it: 0 acts as 1, above the store as the store
   function automatic longint used_dim(input logic [CFG_DIM_W-1:0] d);
      if (d == 0) return 1;
      if (d > DIM) return DIM;
      return longint'(d);
   endfunction

   function automatic longint clampl(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // one byte lerp, floor of the scaled difference
   function automatic logic [7:0] blend8(input longint a, input longint b, input longint t);
      longint d;
      longint r;
      d = (b - a) * t;
      r = a + (d >>> WFRAC);
      return 8'(clampl(r, 0, 255));
   endfunction

   // half-texel offset, floor, weight and clamped neighbor pair along one axis
   function automatic void axis_split(input longint c, input longint dim,
                                      output longint i0, output longint i1,
                                      output longint t);
      longint f;
      longint base;
      f = c * dim - (longint'(1) << (COORD_FRAC - 1));
      base = f >>> COORD_FRAC;
      t = (f - (base <<< COORD_FRAC)) >> (COORD_FRAC - WFRAC);
      i0 = clampl(base, 0, dim - 1);
      i1 = clampl(base + 1, 0, dim - 1);
   endfunction

   function automatic logic [COLOR_W-1:0] filtered_color(input longint u, input longint v);
      longint w, h, x, y, x0, x1, y0, y1, tx, ty;
      logic [COLOR_W-1:0] c00, c10, c01, c11, res;
      logic [7:0] top, bot;
      w = used_dim(cfg_w);
      h = used_dim(cfg_h);
      res = '0;
      if (cfg_mode == FILTER_NEAREST) begin
         x = clampl((clampl(u, 0, 65535) * w) >> COORD_FRAC, 0, w - 1);
         y = clampl((clampl(v, 0, 65535) * h) >> COORD_FRAC, 0, h - 1);
         res = texel_mem[y*DIM + x];
      end else begin
         axis_split(u, w, x0, x1, tx);
         axis_split(v, h, y0, y1, ty);
         c00 = texel_mem[y0*DIM + x0];
         c10 = texel_mem[y0*DIM + x1];
         c01 = texel_mem[y1*DIM + x0];
         c11 = texel_mem[y1*DIM + x1];
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            top = blend8(c00[ch*8 +: 8], c10[ch*8 +: 8], tx);
            bot = blend8(c01[ch*8 +: 8], c11[ch*8 +: 8], tx);
            res[ch*8 +: 8] = blend8(top, bot, ty);
         end
      end
      return res;
   endfunction

   assign pending = color_fifo.size();

   always @(posedge clock) begin
      logic [COLOR_W-1:0] want;
      if (reset) begin
         cfg_mode <= FILTER_NEAREST;
         cfg_w <= 7'd64;
         cfg_h <= 7'd64;
         color_fifo.delete();
         fail_count <= 0;
         colors_checked <= 0;
      end else begin
         // register writes
         if (psel && penable && pwrite && pready) begin
            if (paddr == {REG_FILTER_MODE, 2'b00}) cfg_mode <= pwdata[0];
            else if (paddr == {REG_TEX_WIDTH, 2'b00}) cfg_w <= pwdata[CFG_DIM_W-1:0];
            else if (paddr == {REG_TEX_HEIGHT, 2'b00}) cfg_h <= pwdata[CFG_DIM_W-1:0];
         end
         // accepted request
         if (start && !busy) begin
            if (req_type == REQ_WRITE)
               texel_mem[req_texel_y*DIM + req_texel_x] = req_texel_color;
            else
               color_fifo.push_back(filtered_color(longint'(req_coord_u),
                                                   longint'(req_coord_v)));
         end
         // result compare
         if (rsp_strobe) begin
            colors_checked <= colors_checked + 1;
            if (color_fifo.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected color %08h with nothing pending", rsp_sample_color);
               fail_count <= fail_count + 1;
            end else begin
               want = color_fifo.pop_front();
               if (want !== rsp_sample_color) begin
                  if (fail_count < 10)
                     $display("color mismatch: expected %08h got %08h",
                              want, rsp_sample_color);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

@@ test/tb.sv @@
// Testbench top for the texture sampler: clock, reset, request and register stimulus, verdict.
module tb import tsnb_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_UNUSED = 4'd12;
   localparam int DIM = MAX_DIM_DEF;
   // side of the low corner block that is fully written
   localparam int BLOCK = 24;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_type = REQ_WRITE;
   logic [TEXEL_XY_W-1:0] req_texel_x = '0;
   logic [TEXEL_XY_W-1:0] req_texel_y = '0;
   logic [COLOR_W-1:0] req_texel_color = '0;
   logic signed [COORD_W-1:0] req_coord_u = '0;
   logic signed [COORD_W-1:0] req_coord_v = '0;
   logic rsp_strobe;
   logic [COLOR_W-1:0] rsp_sample_color;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;
   int fail_count, pending, colors_checked;
   bit idle_on = 1'b1;
   int wait_cnt;
   int dir_u [8];

   always #4 clock = ~clock;

   texture_sampler_nearest_bilinear u_top (.*);

   tsnb_checker u_chk (.*);

   // watchdog
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // one request, with optional idle cycles ahead of it
   task automatic send_req(input logic kind, input int x, input int y,
                           input logic [COLOR_W-1:0] color, input int u, input int v);
      while (idle_on && $urandom_range(99) < 13) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_type <= kind;
      req_texel_x <= TEXEL_XY_W'(x);
      req_texel_y <= TEXEL_XY_W'(y);
      req_texel_color <= color;
      req_coord_u <= COORD_W'(u);
      req_coord_v <= COORD_W'(v);
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // stop sending and let every pending color and in-flight write finish
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input int data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= CSR_DATA_W'(data);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_config(input int mode, input int w, input int h);
      csr_write({REG_FILTER_MODE, 2'b00}, mode);
      csr_write({REG_TEX_WIDTH, 2'b00}, w);
      csr_write({REG_TEX_HEIGHT, 2'b00}, h);
      @(posedge clock);
   endtask

   // mostly near the unit square, sometimes anywhere in the Q4.16 range
   function automatic int rand_coord();
      case ($urandom_range(9))
         0, 1: return $urandom_range(0, 32'hFFFFF);
         2: return int'($urandom_range(0, 8192)) - 4096;
         3: return 65535 - 4096 + int'($urandom_range(0, 8192));
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic int rand_dim();
      case ($urandom_range(7))
         0: return 1;
         1: return 64;
         2: return 2;
         3: return $urandom_range(0, 127);
         default: return $urandom_range(1, 64);
      endcase
   endfunction

   initial begin
      dir_u = '{-524288, 524287, 0, 65535, 65536, 32768, 1, -1};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill row 0, column 0 and a low corner block; sizes are picked so that
      // every sample only reads written texels
      for (int i = 0; i < DIM; i++)
         send_req(REQ_WRITE, i, 0, {$urandom}, 0, 0);
      for (int i = 1; i < DIM; i++)
         send_req(REQ_WRITE, 0, i, {$urandom}, 0, 0);
      for (int y = 1; y < BLOCK; y++)
         for (int x = 1; x < BLOCK; x++)
            send_req(REQ_WRITE, x, y, {$urandom}, 0, 0);
      send_req(REQ_WRITE, 0, 0, 32'h0000_0000, 0, 0);
      send_req(REQ_WRITE, 63, 63, 32'hFFFF_FFFF, 0, 0);
      send_req(REQ_WRITE, 63, 0, 32'hFF00_FF00, 0, 0);

      // directed corners, both modes, reset sizes
      for (int m = 0; m < 2; m++) begin
         if (m == 1) begin
            drain();
            csr_write({REG_FILTER_MODE, 2'b00}, FILTER_BILINEAR);
            @(posedge clock);
         end
         for (int k = 0; k < 8; k++)
            send_req(REQ_SAMPLE, 0, 0, 0, dir_u[k], dir_u[7-k]);
      end

      // random phases
      for (int ph = 0; ph < 10; ph++) begin
         drain();
         if (ph == 0) set_config(FILTER_NEAREST, 1, 1);
         else if (ph == 1) set_config(FILTER_BILINEAR, 127, 0);
         else if (ph == 2) set_config(FILTER_BILINEAR, 1, 64);
         else if (ph == 3) set_config(FILTER_NEAREST, 0, 127);
         else begin
            case ($urandom_range(3))
               0: set_config($urandom_range(1), rand_dim(), $urandom_range(1));
               1: set_config($urandom_range(1), $urandom_range(1), rand_dim());
               default: set_config($urandom_range(1), $urandom_range(0, BLOCK),
                                   $urandom_range(0, BLOCK));
            endcase
         end
         if (ph == 5) csr_write(CSR_ADDR_UNUSED, 32'hFFFF_FFFF);
         idle_on = (ph != 4);
         for (int n = 0; n < 63; n++) begin
            if ($urandom_range(3) == 0)
               send_req(REQ_WRITE, $urandom_range(63), $urandom_range(63), {$urandom}, 0, 0);
            else
               send_req(REQ_SAMPLE, 0, 0, 0, rand_coord(), rand_coord());
         end
      end
      start <= 1'b0;

      // wait for the tail
      wait_cnt = 0;
      while (pending != 0 && wait_cnt < 1000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (10) @(posedge clock);

      $display("Covered edge rows and a corner block of texels, corner coordinates, and");
      $display("10 size settings in both modes; %0d colors compared.", colors_checked);
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
